// File: src/vfa_pkg.sv
// Shared types and constants for the three-component vector ALU.
package vfa_pkg;

    localparam int W         = 32;
    localparam int FRAC_BITS = 16;

    typedef enum logic [2:0] {
        FN_ADD   = 3'd0,
        FN_SUB   = 3'd1,
        FN_MUL   = 3'd2,
        FN_SCALE = 3'd3,
        FN_DIV   = 3'd4,
        FN_NORM  = 3'd5,
        FN_DOT   = 3'd6,
        FN_CROSS = 3'd7
    } func_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    typedef struct packed {
        logic [2:0]          func;
        logic signed [W-1:0] a_x;
        logic signed [W-1:0] a_y;
        logic signed [W-1:0] a_z;
        logic signed [W-1:0] b_x;
        logic signed [W-1:0] b_y;
        logic signed [W-1:0] b_z;
        logic signed [W-1:0] scalar_s;
    } req_t;

    typedef struct packed {
        logic signed [W-1:0] r_x;
        logic signed [W-1:0] r_y;
        logic signed [W-1:0] r_z;
        logic signed [W-1:0] r_scalar;
        logic [1:0]          status;
    } rsp_t;

endpackage

// File: src/vec3_fixed_point_alu_unit.sv
// Pipelined three-component fixed-point vector ALU, top level.
//
//  channel | signals                            | direction
//  req     | req_valid, req_ready, req_word     | operation word in
//  rsp     | rsp_valid, rsp_ready, rsp_word     | result word out
//
// One word enters per cycle while the output register is empty or being taken; values are
// Q16.16. A word passes the input, multiply and sum stages, the square-root stages (two root
// bits each), the divide setup and divide stages (four quotient bits each) and the output
// register. All stages advance together at those times, so a stall holds every word in place.
// Reset clears the valid bits only.
module vec3_fixed_point_alu_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  vfa_pkg::req_t req_word,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output vfa_pkg::rsp_t rsp_word
);
    import vfa_pkg::*;

    localparam int PW     = 2 * W;
    localparam int RW     = 2 * W - FRAC_BITS + 2;
    localparam int CW     = 2 * W + 2;
    localparam int DIV_ST = (W + FRAC_BITS + 3) / 4;
    localparam int DPW    = DIV_ST * 4;
    localparam int SQ_ST  = W / 2;
    localparam int RMW    = W + 4;

    localparam logic signed [CW-1:0] SAT_MAX = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [CW-1:0] SAT_MIN = {{(CW-W+1){1'b1}}, {(W-1){1'b0}}};

    typedef struct packed {
        logic [2:0]                 func;
        logic [2:0][W-1:0]          a;
        logic [2:0][W-1:0]          b;
        logic [2:0][RW-1:0]         rv;
        logic [RW-1:0]              rs;
    } ctx_t;

    logic advance;
    assign advance   = !rsp_valid || rsp_ready;
    assign req_ready = advance;

    // Stage 1: input register.
    logic s1_v_reg;
    req_t s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (advance)
            s1_v_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            s1_reg <= req_word;
    end

    // Stage 2: six multipliers.
    logic s2_v_reg;
    req_t s2_reg;
    logic signed [PW-1:0] prod_reg [0:5];
    logic signed [W-1:0]  ma_next [0:5];
    logic signed [W-1:0]  mb_next [0:5];

    always_comb
    begin
        ma_next[0] = s1_reg.a_x; mb_next[0] = s1_reg.b_x;
        ma_next[1] = s1_reg.a_y; mb_next[1] = s1_reg.b_y;
        ma_next[2] = s1_reg.a_z; mb_next[2] = s1_reg.b_z;
        ma_next[3] = s1_reg.a_z; mb_next[3] = s1_reg.b_y;
        ma_next[4] = s1_reg.a_x; mb_next[4] = s1_reg.b_z;
        ma_next[5] = s1_reg.a_y; mb_next[5] = s1_reg.b_x;
        unique case (func_t'(s1_reg.func))
            FN_SCALE:
            begin
                mb_next[0] = s1_reg.scalar_s;
                mb_next[1] = s1_reg.scalar_s;
                mb_next[2] = s1_reg.scalar_s;
            end
            FN_NORM:
            begin
                mb_next[0] = s1_reg.a_x;
                mb_next[1] = s1_reg.a_y;
                mb_next[2] = s1_reg.a_z;
            end
            FN_CROSS:
            begin
                ma_next[0] = s1_reg.a_y; mb_next[0] = s1_reg.b_z;
                ma_next[1] = s1_reg.a_z; mb_next[1] = s1_reg.b_x;
                ma_next[2] = s1_reg.a_x; mb_next[2] = s1_reg.b_y;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (advance)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_reg <= s1_reg;
            for (int i = 0; i < 6; i++)
                prod_reg[i] <= PW'(ma_next[i] * mb_next[i]);
        end
    end

    // Stage 3: shifts, sums and the sum of squares; feeds the square-root stages.
    logic                sq_v_reg    [0:SQ_ST];
    ctx_t                sq_ctx_reg  [0:SQ_ST];
    logic [PW-1:0]       sq_val_reg  [0:SQ_ST];
    logic [RMW-1:0]      sq_rem_reg  [0:SQ_ST];
    logic [W-1:0]        sq_root_reg [0:SQ_ST];

    logic signed [RW-1:0] sh_next [0:5];
    ctx_t                 ctx_next;
    logic [PW-1:0]        ss_next;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
            sh_next[i] = RW'(prod_reg[i] >>> FRAC_BITS);
        ss_next = prod_reg[0] + prod_reg[1] + prod_reg[2];
        ctx_next.func = s2_reg.func;
        ctx_next.a    = {s2_reg.a_z, s2_reg.a_y, s2_reg.a_x};
        ctx_next.b    = {s2_reg.b_z, s2_reg.b_y, s2_reg.b_x};
        ctx_next.rv   = '0;
        ctx_next.rs   = '0;
        unique case (func_t'(s2_reg.func))
            FN_ADD:
            begin
                ctx_next.rv[0] = RW'(s2_reg.a_x) + RW'(s2_reg.b_x);
                ctx_next.rv[1] = RW'(s2_reg.a_y) + RW'(s2_reg.b_y);
                ctx_next.rv[2] = RW'(s2_reg.a_z) + RW'(s2_reg.b_z);
            end
            FN_SUB:
            begin
                ctx_next.rv[0] = RW'(s2_reg.a_x) - RW'(s2_reg.b_x);
                ctx_next.rv[1] = RW'(s2_reg.a_y) - RW'(s2_reg.b_y);
                ctx_next.rv[2] = RW'(s2_reg.a_z) - RW'(s2_reg.b_z);
            end
            FN_MUL, FN_SCALE:
            begin
                ctx_next.rv[0] = sh_next[0];
                ctx_next.rv[1] = sh_next[1];
                ctx_next.rv[2] = sh_next[2];
            end
            FN_DOT:
                ctx_next.rs = sh_next[0] + sh_next[1] + sh_next[2];
            FN_CROSS:
            begin
                ctx_next.rv[0] = sh_next[0] - sh_next[3];
                ctx_next.rv[1] = sh_next[1] - sh_next[4];
                ctx_next.rv[2] = sh_next[2] - sh_next[5];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else if (advance)
            sq_v_reg[0] <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_ctx_reg[0]  <= ctx_next;
            sq_val_reg[0]  <= ss_next;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // Square-root stages, two root bits each.
    for (genvar k = 0; k < SQ_ST; k++)
    begin : g_sq
        logic [PW-1:0]  val_next;
        logic [RMW-1:0] rem_next;
        logic [W-1:0]   root_next;

        always_comb
        begin
            logic [RMW-1:0] trial;
            val_next  = sq_val_reg[k];
            rem_next  = sq_rem_reg[k];
            root_next = sq_root_reg[k];
            for (int j = 0; j < 2; j++)
            begin
                rem_next = {rem_next[RMW-3:0], val_next[PW-1 -: 2]};
                val_next = {val_next[PW-3:0], 2'b00};
                trial    = {{(RMW-W-2){1'b0}}, root_next, 2'b01};
                if (rem_next >= trial)
                begin
                    rem_next  = rem_next - trial;
                    root_next = {root_next[W-2:0], 1'b1};
                end
                else
                    root_next = {root_next[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k+1] <= 1'b0;
            else if (advance)
                sq_v_reg[k+1] <= sq_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                sq_ctx_reg[k+1]  <= sq_ctx_reg[k];
                sq_val_reg[k+1]  <= val_next;
                sq_rem_reg[k+1]  <= rem_next;
                sq_root_reg[k+1] <= root_next;
            end
        end
    end

    // Divide setup and restoring divide stages, four quotient bits each.
    logic                 dv_v_reg    [0:DIV_ST];
    ctx_t                 dv_ctx_reg  [0:DIV_ST];
    logic                 dv_mnz_reg  [0:DIV_ST];
    logic [2:0][DPW-1:0]  dv_q_reg    [0:DIV_ST];
    logic [2:0][W:0]      dv_rem_reg  [0:DIV_ST];
    logic [2:0][W-1:0]    dv_dvs_reg  [0:DIV_ST];
    logic [2:0]           dv_neg_reg  [0:DIV_ST];

    logic [2:0][DPW-1:0]  dq_next;
    logic [2:0][W-1:0]    ds_next;
    logic [2:0]           dn_next;

    always_comb
    begin
        logic signed [W-1:0] av;
        logic signed [W-1:0] bv;
        logic [W-1:0]        amag;
        for (int i = 0; i < 3; i++)
        begin
            av   = sq_ctx_reg[SQ_ST].a[i];
            bv   = sq_ctx_reg[SQ_ST].b[i];
            amag = av[W-1] ? W'(-av) : W'(av);
            dq_next[i] = DPW'({amag, {FRAC_BITS{1'b0}}});
            if (sq_ctx_reg[SQ_ST].func == FN_DIV)
            begin
                ds_next[i] = bv[W-1] ? W'(-bv) : W'(bv);
                dn_next[i] = av[W-1] ^ bv[W-1];
            end
            else
            begin
                ds_next[i] = sq_root_reg[SQ_ST];
                dn_next[i] = av[W-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (advance)
            dv_v_reg[0] <= sq_v_reg[SQ_ST];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dv_ctx_reg[0] <= sq_ctx_reg[SQ_ST];
            dv_mnz_reg[0] <= (sq_root_reg[SQ_ST] != '0);
            dv_q_reg[0]   <= dq_next;
            dv_rem_reg[0] <= '0;
            dv_dvs_reg[0] <= ds_next;
            dv_neg_reg[0] <= dn_next;
        end
    end

    for (genvar k = 0; k < DIV_ST; k++)
    begin : g_dv
        logic [2:0][DPW-1:0] q_next;
        logic [2:0][W:0]     rem_next;

        always_comb
        begin
            logic [W:0] dvs;
            q_next   = dv_q_reg[k];
            rem_next = dv_rem_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                dvs = {1'b0, dv_dvs_reg[k][i]};
                for (int j = 0; j < 4; j++)
                begin
                    rem_next[i] = {rem_next[i][W-1:0], q_next[i][DPW-1]};
                    q_next[i]   = {q_next[i][DPW-2:0], 1'b0};
                    if (rem_next[i] >= dvs)
                    begin
                        rem_next[i] = rem_next[i] - dvs;
                        q_next[i][0] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[k+1] <= 1'b0;
            else if (advance)
                dv_v_reg[k+1] <= dv_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                dv_ctx_reg[k+1] <= dv_ctx_reg[k];
                dv_mnz_reg[k+1] <= dv_mnz_reg[k];
                dv_q_reg[k+1]   <= q_next;
                dv_rem_reg[k+1] <= rem_next;
                dv_dvs_reg[k+1] <= dv_dvs_reg[k];
                dv_neg_reg[k+1] <= dv_neg_reg[k];
            end
        end
    end

    // Final stage: selection, saturation and status.
    ctx_t               fc;
    logic [2:0][W-1:0]  rc_next;
    logic [W-1:0]       rsc_next;
    logic               sat_next;
    logic               dz_next;
    rsp_t               rsp_next;
    rsp_t               rsp_reg;
    logic               rsp_v_reg;

    assign fc = dv_ctx_reg[DIV_ST];

    always_comb
    begin
        logic signed [CW-1:0] pre;
        logic signed [CW-1:0] qs;
        logic signed [W-1:0]  av;
        logic signed [CW-1:0] rsw;
        sat_next = 1'b0;
        dz_next  = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            av = fc.a[i];
            qs = dv_neg_reg[DIV_ST][i] ? -CW'(dv_q_reg[DIV_ST][i]) : CW'(dv_q_reg[DIV_ST][i]);
            priority if (fc.func == FN_DIV && fc.b[i] == '0)
            begin
                dz_next = 1'b1;
                if (av > 0)
                    pre = SAT_MAX;
                else if (av < 0)
                    pre = SAT_MIN;
                else
                    pre = '0;
            end
            else if (fc.func == FN_DIV || (fc.func == FN_NORM && dv_mnz_reg[DIV_ST]))
                pre = qs;
            else if (fc.func == FN_NORM)
                pre = CW'(av);
            else
                pre = CW'($signed(fc.rv[i]));
            if (pre > SAT_MAX)
            begin
                rc_next[i] = {1'b0, {(W-1){1'b1}}};
                sat_next   = 1'b1;
            end
            else if (pre < SAT_MIN)
            begin
                rc_next[i] = {1'b1, {(W-1){1'b0}}};
                sat_next   = 1'b1;
            end
            else
                rc_next[i] = pre[W-1:0];
        end
        rsw = CW'($signed(fc.rs));
        if (rsw > SAT_MAX)
        begin
            rsc_next = {1'b0, {(W-1){1'b1}}};
            sat_next = 1'b1;
        end
        else if (rsw < SAT_MIN)
        begin
            rsc_next = {1'b1, {(W-1){1'b0}}};
            sat_next = 1'b1;
        end
        else
            rsc_next = rsw[W-1:0];
        rsp_next.r_x      = rc_next[0];
        rsp_next.r_y      = rc_next[1];
        rsp_next.r_z      = rc_next[2];
        rsp_next.r_scalar = rsc_next;
        rsp_next.status   = dz_next ? ST_DZ : (sat_next ? ST_SAT : ST_OK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_v_reg <= 1'b0;
        else if (advance)
            rsp_v_reg <= dv_v_reg[DIV_ST];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_v_reg;
    assign rsp_word  = rsp_reg;

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> dv_v_reg[DIV_ST] == $past(dv_v_reg[DIV_ST]) &&
                     sq_v_reg[SQ_ST] == $past(sq_v_reg[SQ_ST]))
        else $error("Pipeline valid moved during a stall.");

    a_scalar_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.r_scalar != '0 |->
            rsp_word.r_x == '0 && rsp_word.r_y == '0 && rsp_word.r_z == '0)
        else $error("Dot result word carries vector components.");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status == ST_SAT |->
            rsp_word.r_x == {1'b0, {(W-1){1'b1}}} || rsp_word.r_x == {1'b1, {(W-1){1'b0}}} ||
            rsp_word.r_y == {1'b0, {(W-1){1'b1}}} || rsp_word.r_y == {1'b1, {(W-1){1'b0}}} ||
            rsp_word.r_z == {1'b0, {(W-1){1'b1}}} || rsp_word.r_z == {1'b1, {(W-1){1'b0}}} ||
            rsp_word.r_scalar == {1'b0, {(W-1){1'b1}}} ||
            rsp_word.r_scalar == {1'b1, {(W-1){1'b0}}})
        else $error("Saturation flagged with no component at a bound.");
`endif

endmodule

// File: sim/tb_vec3_fixed_point_alu_unit.sv
// Testbench for the vector ALU: directed and random words checked against a built-in predictor.
module tb_vec3_fixed_point_alu_unit;
    import vfa_pkg::*;

    localparam int LATENCY = 40;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req_word = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp_word;

    rsp_t expected_q[$];
    int errors = 0;
    longint cycles = 0;
    bit hold_rsp = 1'b0;
    bit rsp_idle_on = 1'b1;
    bit req_idle_on = 1'b1;

    vec3_fixed_point_alu_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint floor_q(longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic longint clamp32(longint v, inout bit sat);
        if (v > S32_MAX)
        begin
            sat = 1'b1;
            return S32_MAX;
        end
        if (v < S32_MIN)
        begin
            sat = 1'b1;
            return S32_MIN;
        end
        return v;
    endfunction

    function automatic longint q_div(longint a, longint b, inout bit dz);
        if (b == 0)
        begin
            dz = 1'b1;
            return (a > 0) ? S32_MAX : ((a < 0) ? S32_MIN : 0);
        end
        return (a * (64'sd1 <<< FRAC_BITS)) / b;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    function automatic rsp_t vector_result(req_t w);
        longint a[3];
        longint b[3];
        longint r[3];
        longint s;
        longint rs;
        longint mag;
        longint unsigned ss;
        bit sat;
        bit dz;
        rsp_t o;
        a[0] = longint'(w.a_x); a[1] = longint'(w.a_y); a[2] = longint'(w.a_z);
        b[0] = longint'(w.b_x); b[1] = longint'(w.b_y); b[2] = longint'(w.b_z);
        s = longint'(w.scalar_s);
        r[0] = 0; r[1] = 0; r[2] = 0;
        rs = 0; sat = 0; dz = 0;
        case (func_t'(w.func))
            FN_ADD: for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
            FN_SUB: for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
            FN_MUL: for (int i = 0; i < 3; i++) r[i] = floor_q(a[i] * b[i]);
            FN_SCALE: for (int i = 0; i < 3; i++) r[i] = floor_q(a[i] * s);
            FN_DIV: for (int i = 0; i < 3; i++) r[i] = q_div(a[i], b[i], dz);
            FN_NORM:
            begin
                ss = longint'(a[0] * a[0]) + longint'(a[1] * a[1]) + longint'(a[2] * a[2]);
                mag = floor_sqrt(ss);
                for (int i = 0; i < 3; i++)
                    r[i] = (mag > 0) ? (a[i] * (64'sd1 <<< FRAC_BITS)) / mag : a[i];
            end
            FN_DOT: rs = floor_q(a[0] * b[0]) + floor_q(a[1] * b[1]) + floor_q(a[2] * b[2]);
            default:
            begin
                r[0] = floor_q(a[1] * b[2]) - floor_q(a[2] * b[1]);
                r[1] = floor_q(a[2] * b[0]) - floor_q(a[0] * b[2]);
                r[2] = floor_q(a[0] * b[1]) - floor_q(a[1] * b[0]);
            end
        endcase
        o.r_x = 32'(clamp32(r[0], sat));
        o.r_y = 32'(clamp32(r[1], sat));
        o.r_z = 32'(clamp32(r[2], sat));
        o.r_scalar = 32'(clamp32(rs, sat));
        o.status = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
        return o;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        rsp_t e;
        if (rsp_valid && rsp_ready)
        begin
            if (expected_q.size() == 0)
                report("unexpected word", 32'h0, 32'h0);
            else
            begin
                e = expected_q.pop_front();
                if (rsp_word.r_x !== e.r_x) report("r_x", rsp_word.r_x, e.r_x);
                if (rsp_word.r_y !== e.r_y) report("r_y", rsp_word.r_y, e.r_y);
                if (rsp_word.r_z !== e.r_z) report("r_z", rsp_word.r_z, e.r_z);
                if (rsp_word.r_scalar !== e.r_scalar)
                    report("r_scalar", rsp_word.r_scalar, e.r_scalar);
                if (rsp_word.status !== e.status)
                    report("status", {30'd0, rsp_word.status}, {30'd0, e.status});
            end
        end
    end

    // Receiver: random stalls per word, or a long hold while hold_rsp is set.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = rsp_idle_on ? $urandom_range(0, 9) : 0;
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else if (gap != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    task automatic send_word(req_t w);
        int gap;
        gap = req_idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_q.push_back(vector_result(w));
    endtask

    task automatic drop_valid();
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(0, 32'h3ffff) - 32'h20000;
            4: return $urandom_range(0, 32'h3fffff) - 32'h200000;
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t rand_word(func_t f);
        req_t w;
        w.func = f;
        w.a_x = rand_comp(); w.a_y = rand_comp(); w.a_z = rand_comp();
        w.b_x = rand_comp(); w.b_y = rand_comp(); w.b_z = rand_comp();
        w.scalar_s = rand_comp();
        return w;
    endfunction

    task automatic wait_drain();
        drop_valid();
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        req_t w;
        logic [31:0] ext[4];
        ext[0] = 32'h7fffffff; ext[1] = 32'h80000000; ext[2] = 32'h0; ext[3] = 32'h00010000;
        for (int f = 0; f < 8; f++)
        begin
            w = '{func: f[2:0], a_x: ext[0], a_y: ext[1], a_z: ext[3],
                  b_x: ext[0], b_y: ext[1], b_z: ext[1], scalar_s: ext[1]};
            send_word(w);
            w = '{func: f[2:0], a_x: ext[1], a_y: ext[2], a_z: -32'sd65536,
                  b_x: ext[2], b_y: ext[3], b_z: ext[0], scalar_s: ext[0]};
            send_word(w);
        end
        // Divide by zero with positive, negative and zero dividends.
        send_word('{func: FN_DIV, a_x: 32'sd5, a_y: -32'sd5, a_z: 0,
                    b_x: 0, b_y: 0, b_z: 0, scalar_s: 0});
        // Zero vector normalize and a tiny one.
        send_word('{func: FN_NORM, a_x: 0, a_y: 0, a_z: 0,
                    b_x: 1, b_y: 1, b_z: 1, scalar_s: 1});
        send_word('{func: FN_NORM, a_x: -32'sd1, a_y: 0, a_z: 0,
                    b_x: 0, b_y: 0, b_z: 0, scalar_s: 0});
        send_word('{func: FN_NORM, a_x: 32'sh80000000, a_y: 32'sh80000000,
                    a_z: 32'sh80000000, b_x: 0, b_y: 0, b_z: 0, scalar_s: 0});
        send_word('{func: FN_DOT, a_x: 32'sh80000000, a_y: 32'sh80000000,
                    a_z: 32'sh80000000, b_x: 32'sh80000000, b_y: 32'sh80000000,
                    b_z: 32'sh80000000, scalar_s: 0});
        wait_drain();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_word(rand_word(func_t'($urandom_range(0, 7))));
    endtask

    task automatic test_backpressure();
        hold_rsp = 1'b1;
        req_idle_on = 1'b0;
        for (int i = 0; i < 150; i++)
            send_word(rand_word(func_t'($urandom_range(0, 7))));
        req_idle_on = 1'b1;
        wait_drain();
    endtask

    task automatic test_streaming();
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        test_random(200);
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(500);
        wait_drain();
        test_backpressure();
        test_streaming();
        test_random(580);
        wait_drain();
        repeat (LATENCY) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
